/* rtl/gam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gam_pkg
// Shared constants, types and helpers for the adjacency matrix store.
// ----------------------------------------------------------------------------
package gam_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VAL_W        = 32;
    localparam int ROW_W        = MAX_VERTICES;
    localparam int OUT_ROW_W    = 16;

    localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
    localparam logic [1:0] OP_DEL_VERTEX = 2'd1;
    localparam logic [1:0] OP_ADD_EDGE   = 2'd2;
    localparam logic [1:0] OP_DEL_EDGE   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [2:0] CK_NONE     = 3'd0;
    localparam logic [2:0] CK_APPEND   = 3'd1;
    localparam logic [2:0] CK_REMOVE   = 3'd2;
    localparam logic [2:0] CK_SET_EDGE = 3'd3;
    localparam logic [2:0] CK_CLR_EDGE = 3'd4;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [VAL_W-1:0] val_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] idx_i;
        logic [IDX_W-1:0] idx_j;
        logic [CNT_W-1:0] cnt;
        val_t             value;
    } cmd_t;

    // remove bit k, higher bits move down one
    function automatic row_t drop_column(input row_t row, input logic [IDX_W-1:0] k);
        row_t res;
        res = '0;
        for (int b = 0; b < ROW_W; b++)
        begin
            if (b < int'(k))
                res[b] = row[b];
            else if (b + 1 < ROW_W)
                res[b] = row[b + 1];
            else
                res[b] = 1'b0;
        end
        return res;
    endfunction

endpackage

/* rtl/gam_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gam_cell
// One vertex slot: value and adjacency row, fed from the next slot on remove.
// ----------------------------------------------------------------------------
module gam_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gam_pkg::IDX_W-1:0]    cell_index,
    input  gam_pkg::cmd_t                cmd,
    input  gam_pkg::val_t                next_value,
    input  gam_pkg::row_t                next_row,
    output gam_pkg::val_t                value,
    output gam_pkg::row_t                row
);

    gam_pkg::val_t value_reg, value_next;
    gam_pkg::row_t row_reg, row_next;

    logic [gam_pkg::CNT_W-1:0] r_ext;
    assign r_ext = gam_pkg::CNT_W'(cell_index);

    always_comb
    begin
        value_next = value_reg;
        row_next   = row_reg;
        case (cmd.kind)
            gam_pkg::CK_APPEND:
            begin
                if (r_ext == cmd.cnt)
                begin
                    value_next = cmd.value;
                    row_next   = '0;
                end
                else
                begin
                    row_next[cmd.cnt[gam_pkg::IDX_W-1:0]] = 1'b0;
                end
            end
            gam_pkg::CK_REMOVE:
            begin
                if (r_ext + 1'b1 >= cmd.cnt)
                    row_next = '0;
                else if (cell_index >= cmd.idx_i)
                begin
                    value_next = next_value;
                    row_next   = gam_pkg::drop_column(next_row, cmd.idx_i);
                end
                else
                    row_next = gam_pkg::drop_column(row_reg, cmd.idx_i);
            end
            gam_pkg::CK_SET_EDGE:
            begin
                if (cell_index == cmd.idx_i)
                    row_next[cmd.idx_j] = 1'b1;
                if (cell_index == cmd.idx_j)
                    row_next[cmd.idx_i] = 1'b1;
            end
            gam_pkg::CK_CLR_EDGE:
            begin
                if (cell_index == cmd.idx_i)
                    row_next[cmd.idx_j] = 1'b0;
                if (cell_index == cmd.idx_j)
                    row_next[cmd.idx_i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else
            row_reg <= row_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign row   = row_reg;

endmodule

/* rtl/graph_adjacency_matrix_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_matrix_store
// Undirected graph of up to MAX_VERTICES vertices kept in a chain of cells.
// ----------------------------------------------------------------------------
// Each command is accepted when start is high and busy is low; every cell
// updates its value and row at that edge (a remove shifts each later cell's
// contents from its neighbor), and in the next cycle done pulses for one
// cycle with the result read from the updated cells. The result is shown for
// that one cycle only and cannot be held off; busy is high during it, so no
// new command is accepted while the result is shown.
module graph_adjacency_matrix_store
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       op,
    input  logic signed [gam_pkg::VAL_W-1:0] vertex_value,
    input  logic [gam_pkg::IDX_W-1:0]        index_i,
    input  logic [gam_pkg::IDX_W-1:0]        index_j,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [gam_pkg::CNT_W-1:0]        vertex_count,
    output logic [gam_pkg::OUT_ROW_W-1:0]    row_bits,
    output logic signed [gam_pkg::VAL_W-1:0] vertex_at
);

    logic [gam_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      pend_reg;
    logic [gam_pkg::IDX_W-1:0] idx_reg;
    logic [1:0]                status_reg, status_next;

    gam_pkg::cmd_t cmd;
    gam_pkg::val_t cell_value [gam_pkg::MAX_VERTICES];
    gam_pkg::row_t cell_row   [gam_pkg::MAX_VERTICES];

    logic accept;
    logic i_ok, j_ok;

    assign accept = start && !pend_reg;
    assign i_ok   = gam_pkg::CNT_W'(index_i) < count_reg;
    assign j_ok   = gam_pkg::CNT_W'(index_j) < count_reg;

    always_comb
    begin
        cmd.kind    = gam_pkg::CK_NONE;
        cmd.idx_i   = index_i;
        cmd.idx_j   = index_j;
        cmd.cnt     = count_reg;
        cmd.value   = vertex_value;
        count_next  = count_reg;
        status_next = gam_pkg::ST_DONE;
        unique case (op)
            gam_pkg::OP_ADD_VERTEX:
            begin
                if (count_reg == gam_pkg::CNT_W'(gam_pkg::MAX_VERTICES))
                    status_next = gam_pkg::ST_FULL;
                else
                begin
                    cmd.kind   = gam_pkg::CK_APPEND;
                    count_next = count_reg + 1'b1;
                end
            end
            gam_pkg::OP_DEL_VERTEX:
            begin
                if (!i_ok)
                    status_next = gam_pkg::ST_IGNORED;
                else
                begin
                    cmd.kind   = gam_pkg::CK_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                if (!i_ok || !j_ok || index_i == index_j)
                    status_next = gam_pkg::ST_IGNORED;
                else if (op == gam_pkg::OP_ADD_EDGE)
                    cmd.kind = gam_pkg::CK_SET_EDGE;
                else
                    cmd.kind = gam_pkg::CK_CLR_EDGE;
            end
        endcase
        if (!accept)
        begin
            cmd.kind   = gam_pkg::CK_NONE;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg    <= index_i;
            status_reg <= status_next;
        end
    end

    for (genvar r = 0; r < gam_pkg::MAX_VERTICES; r++)
    begin : g_cell
        gam_pkg::val_t nv;
        gam_pkg::row_t nr;
        if (r == gam_pkg::MAX_VERTICES - 1)
        begin : g_last
            assign nv = '0;
            assign nr = '0;
        end
        else
        begin : g_mid
            assign nv = cell_value[r + 1];
            assign nr = cell_row[r + 1];
        end
        gam_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (gam_pkg::IDX_W'(r)),
            .cmd        (cmd),
            .next_value (nv),
            .next_row   (nr),
            .value      (cell_value[r]),
            .row        (cell_row[r])
        );
    end

    logic present;
    assign present = gam_pkg::CNT_W'(idx_reg) < count_reg;

    assign busy         = pend_reg;
    assign done         = pend_reg;
    assign status       = status_reg;
    assign vertex_count = count_reg;
    assign row_bits     = present ? gam_pkg::OUT_ROW_W'(cell_row[idx_reg]) : '0;
    assign vertex_at    = present ? cell_value[idx_reg] : '0;

endmodule

/* rtl/gam_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gam_checker
// Port-level checks on command acceptance and result beats.
// ----------------------------------------------------------------------------
module gam_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic [1:0]                    status,
    input  logic [gam_pkg::CNT_W-1:0]     vertex_count,
    input  logic [gam_pkg::OUT_ROW_W-1:0] row_bits
);

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("accepted command produced no result beat");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without an accepted command");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> vertex_count <= gam_pkg::CNT_W'(gam_pkg::MAX_VERTICES))
        else $error("vertex count out of range");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == gam_pkg::ST_FULL
            |-> vertex_count == gam_pkg::CNT_W'(gam_pkg::MAX_VERTICES))
        else $error("full status with store not full");

    a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
        done && vertex_count == '0 |-> row_bits == '0)
        else $error("nonzero row on empty store");

endmodule

bind graph_adjacency_matrix_store gam_checker u_gam_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .vertex_count (vertex_count),
    .row_bits     (row_bits)
);
